>>> src/constrained_random_password_chars_assert.svh
// assertion macros for the password character block
`ifndef CONSTRAINED_RANDOM_PASSWORD_CHARS_ASSERT_SVH
`define CONSTRAINED_RANDOM_PASSWORD_CHARS_ASSERT_SVH
`ifndef SYNTHESIS
`define CRPC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("crpc assertion failed");
`define CRPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("crpc assertion failed");
`else
`define CRPC_ASSERT_IMP(label, clk, rst_n, a, c)
`define CRPC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> src/crpc_pkg.sv
package crpc_pkg;

    localparam int MAX_LENGTH     = 128;
    localparam int REJECT_CAP     = 1024;
    localparam int ATTEMPT_BUDGET = 100000;

    localparam int WORD_W     = 32;
    localparam int DIVIDEND_W = WORD_W + 1;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int SIZE_W     = 7;
    localparam int CHAR_W     = 7;
    localparam int OUT_POS_W  = 7;
    localparam int VERDICT_W  = 3;
    localparam int MASK_W     = 4;
    localparam int LEN_W      = 8;
    localparam int CLASS_W    = 2;
    localparam int NUM_CLASS  = 4;
    localparam int POS_W      = $clog2(MAX_LENGTH + 1);
    localparam int REJ_W      = $clog2(REJECT_CAP + 1);
    localparam int ATT_W      = $clog2(ATTEMPT_BUDGET + 1);

    localparam logic [1:0] REG_CLASS_MASK    = 2'd0;
    localparam logic [1:0] REG_EXCLUDE       = 2'd1;
    localparam logic [1:0] REG_REQUIRE_EACH  = 2'd2;
    localparam logic [1:0] REG_STRING_LENGTH = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_MORE        = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED    = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECTED    = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_EXHAUSTED   = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_CFG_INVALID = 3'd4;

    localparam logic [CLASS_W-1:0] CLASS_LOWER  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UPPER  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DIGIT  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_SYMBOL = 2'd3;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              reject;
        logic [SIZE_W-1:0] rem;
    } div_res_t;

    function automatic logic [SIZE_W-1:0] class_size(input logic [CLASS_W-1:0] cls,
                                                     input logic excl);
        logic [SIZE_W-1:0] size;
        unique case (cls)
            CLASS_LOWER:  size = excl ? 7'd25 : 7'd26;
            CLASS_UPPER:  size = excl ? 7'd24 : 7'd26;
            CLASS_DIGIT:  size = excl ? 7'd8  : 7'd10;
            CLASS_SYMBOL: size = 7'd27;
        endcase
        return size;
    endfunction

endpackage

>>> src/crpc_div.sv
module crpc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [crpc_pkg::WORD_W-1:0]       word,
    input  logic [crpc_pkg::SIZE_W-1:0]       divisor,
    output crpc_pkg::div_res_t                res
);

    localparam logic [crpc_pkg::STEP_W-1:0] LAST_STEP =
        crpc_pkg::STEP_W'(crpc_pkg::DIVIDEND_W - 1);

    logic                                busy_reg, busy_next;
    logic [crpc_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [crpc_pkg::DIVIDEND_W-1:0]     sr_reg, sr_next;
    logic [crpc_pkg::SIZE_W-1:0]         rem_w_reg, rem_w_next;
    logic [crpc_pkg::SIZE_W-1:0]         rem_c_reg, rem_c_next;
    logic                                eq_reg, eq_next;

    logic [crpc_pkg::SIZE_W:0]           trial_w;
    logic [crpc_pkg::SIZE_W:0]           trial_c;
    logic [crpc_pkg::SIZE_W:0]           divisor_ext;
    logic                                q_w;
    logic                                q_c;

    // word and the constant 2^32 divided side by side, one quotient bit each per cycle
    always_comb
    begin
        divisor_ext = {1'b0, divisor};
        trial_w     = {rem_w_reg, sr_reg[crpc_pkg::DIVIDEND_W-1]};
        trial_c     = {rem_c_reg, step_reg == '0};
        q_w         = trial_w >= divisor_ext;
        q_c         = trial_c >= divisor_ext;

        busy_next  = busy_reg;
        step_next  = step_reg;
        sr_next    = sr_reg;
        rem_w_next = rem_w_reg;
        rem_c_next = rem_c_reg;
        eq_next    = eq_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            sr_next    = {1'b0, word};
            rem_w_next = '0;
            rem_c_next = '0;
            eq_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            sr_next    = {sr_reg[crpc_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_w_next = q_w ? crpc_pkg::SIZE_W'(trial_w - divisor_ext)
                             : trial_w[crpc_pkg::SIZE_W-1:0];
            rem_c_next = q_c ? crpc_pkg::SIZE_W'(trial_c - divisor_ext)
                             : trial_c[crpc_pkg::SIZE_W-1:0];
            eq_next    = eq_reg && (q_w == q_c);
            step_next  = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg    <= sr_next;
        rem_w_reg <= rem_w_next;
        rem_c_reg <= rem_c_next;
        eq_reg    <= eq_next;
    end

    // quotients equal means word is at or above the largest multiple of the size
    assign res.busy   = busy_reg;
    assign res.done   = busy_reg && (step_reg == LAST_STEP);
    assign res.reject = eq_reg;
    assign res.rem    = rem_w_reg;

endmodule

>>> src/crpc_map.sv
module crpc_map (
    input  logic [crpc_pkg::MASK_W-1:0]  class_mask,
    input  logic                         exclude_lookalikes,
    input  logic [crpc_pkg::SIZE_W-1:0]  index,
    output logic [crpc_pkg::CHAR_W-1:0]  char_code,
    output logic [crpc_pkg::CLASS_W-1:0] char_class
);

    localparam logic [crpc_pkg::CHAR_W-1:0] BASE_LOWER = 7'h61;
    localparam logic [crpc_pkg::CHAR_W-1:0] BASE_UPPER = 7'h41;
    localparam logic [crpc_pkg::CHAR_W-1:0] BASE_DIGIT = 7'h30;
    localparam logic [crpc_pkg::SIZE_W-1:0] SKIP_LOWER_L = 7'd11;
    localparam logic [crpc_pkg::SIZE_W-1:0] SKIP_UPPER_I = 7'd8;
    localparam logic [crpc_pkg::SIZE_W-1:0] SKIP_UPPER_O = 7'd13;

    localparam logic [crpc_pkg::CHAR_W-1:0] SYM_CHARS [32] = '{
        7'h21, 7'h23, 7'h24, 7'h25, 7'h26, 7'h28, 7'h29, 7'h2A,
        7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3A, 7'h3B, 7'h3C,
        7'h3D, 7'h3E, 7'h3F, 7'h40, 7'h5B, 7'h5D, 7'h5E, 7'h5F,
        7'h7B, 7'h7D, 7'h7E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    logic [crpc_pkg::SIZE_W-1:0] rest;
    logic [crpc_pkg::SIZE_W-1:0] local_idx;
    logic [crpc_pkg::SIZE_W-1:0] size;
    logic                        found;

    // walk the enabled classes in order, peeling off each class size
    always_comb
    begin
        rest       = index;
        local_idx  = '0;
        size       = '0;
        found      = 1'b0;
        char_class = crpc_pkg::CLASS_LOWER;
        for (int k = 0; k < crpc_pkg::NUM_CLASS; k++)
        begin
            size = crpc_pkg::class_size(crpc_pkg::CLASS_W'(k), exclude_lookalikes);
            if (!found && class_mask[k])
            begin
                if (rest < size)
                begin
                    found      = 1'b1;
                    char_class = crpc_pkg::CLASS_W'(k);
                    local_idx  = rest;
                end
                else
                begin
                    rest = rest - size;
                end
            end
        end
    end

    always_comb
    begin
        unique case (char_class)
            crpc_pkg::CLASS_LOWER:
            begin
                if (exclude_lookalikes && local_idx >= SKIP_LOWER_L)
                    char_code = BASE_LOWER + local_idx + 7'd1;
                else
                    char_code = BASE_LOWER + local_idx;
            end
            crpc_pkg::CLASS_UPPER:
            begin
                if (exclude_lookalikes && local_idx >= SKIP_UPPER_O)
                    char_code = BASE_UPPER + local_idx + 7'd2;
                else if (exclude_lookalikes && local_idx >= SKIP_UPPER_I)
                    char_code = BASE_UPPER + local_idx + 7'd1;
                else
                    char_code = BASE_UPPER + local_idx;
            end
            crpc_pkg::CLASS_DIGIT:
            begin
                if (exclude_lookalikes)
                    char_code = BASE_DIGIT + local_idx + 7'd2;
                else
                    char_code = BASE_DIGIT + local_idx;
            end
            crpc_pkg::CLASS_SYMBOL:
            begin
                char_code = SYM_CHARS[local_idx[4:0]];
            end
        endcase
    end

endmodule

>>> src/constrained_random_password_chars.sv
// channel   dir  handshake          payload
// s_*       in   tvalid / tready    tdata: random_word
// m_*       out  tvalid / tready    tdata: char_code, char_position; tuser: verdict
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// per transaction: the word is accepted, the bit-serial divider runs 33 steps
// (one quotient bit per cycle), then the verdict settles; invalid config skips the divider
// the next word is taken while a result still sits in the output register
// the verdict cycle waits while that register holds a result not yet taken
// rst_n is asynchronous, active low; a register write clears the string state
module constrained_random_password_chars (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // random_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_code, char_position, zero fill
    output logic [2:0]  m_tuser,   // verdict
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [crpc_pkg::MASK_W-1:0]         class_mask_reg, class_mask_next;
    logic                                exclude_reg, exclude_next;
    logic                                require_reg, require_next;
    logic [crpc_pkg::LEN_W-1:0]          length_reg, length_next;
    logic [crpc_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [crpc_pkg::MASK_W-1:0]         seen_reg, seen_next;
    logic [crpc_pkg::REJ_W-1:0]          rej_reg, rej_next;
    logic [crpc_pkg::ATT_W-1:0]          att_reg, att_next;
    logic                                out_valid_reg, out_valid_next;
    logic [crpc_pkg::CHAR_W-1:0]         out_char_reg, out_char_next;
    logic [crpc_pkg::OUT_POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [crpc_pkg::VERDICT_W-1:0]      out_verdict_reg, out_verdict_next;

    logic [crpc_pkg::SIZE_W-1:0]         alpha_size;
    logic [2:0]                          n_classes;
    logic                                constrained;
    logic                                cfg_invalid;
    logic                                accept;
    logic                                div_start;
    logic                                out_free;
    logic                                fin_go;
    logic [crpc_pkg::POS_W-1:0]          pos_inc;
    logic [crpc_pkg::MASK_W-1:0]         seen_upd;
    logic [crpc_pkg::CHAR_W-1:0]         map_char;
    logic [crpc_pkg::CLASS_W-1:0]        map_class;
    crpc_pkg::div_res_t                  div_res;

    always_comb
    begin
        alpha_size = '0;
        for (int k = 0; k < crpc_pkg::NUM_CLASS; k++)
        begin
            if (class_mask_reg[k])
                alpha_size = alpha_size
                           + crpc_pkg::class_size(crpc_pkg::CLASS_W'(k), exclude_reg);
        end
    end

    assign n_classes   = 3'($countones(class_mask_reg));
    assign constrained = require_reg && (n_classes > 3'd1);
    assign cfg_invalid = (class_mask_reg == '0) || (length_reg == '0)
                      || (int'(length_reg) > crpc_pkg::MAX_LENGTH)
                      || (constrained && (length_reg < {5'b0, n_classes}));

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && !cfg_invalid;
    assign out_free  = !out_valid_reg || m_tready;
    assign fin_go    = (state_reg == ST_FIN) && out_free;

    crpc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .word    (s_tdata),
        .divisor (alpha_size),
        .res     (div_res)
    );

    crpc_map u_map (
        .class_mask         (class_mask_reg),
        .exclude_lookalikes (exclude_reg),
        .index              (div_res.rem),
        .char_code          (map_char),
        .char_class         (map_class)
    );

    assign pos_inc  = pos_reg + 1'b1;
    assign seen_upd = seen_reg | (crpc_pkg::MASK_W'(1) << map_class);

    always_comb
    begin
        state_next       = state_reg;
        class_mask_next  = class_mask_reg;
        exclude_next     = exclude_reg;
        require_next     = require_reg;
        length_next      = length_reg;
        pos_next         = pos_reg;
        seen_next        = seen_reg;
        rej_next         = rej_reg;
        att_next         = att_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_char_next    = out_char_reg;
        out_pos_next     = out_pos_reg;
        out_verdict_next = out_verdict_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = cfg_invalid ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_go)
        begin
            if (cfg_invalid)
            begin
                pos_next         = '0;
                seen_next        = '0;
                rej_next         = '0;
                att_next         = '0;
                out_valid_next   = 1'b1;
                out_char_next    = '0;
                out_pos_next     = '0;
                out_verdict_next = crpc_pkg::VERDICT_CFG_INVALID;
            end
            else if (div_res.reject
                     && (rej_reg < crpc_pkg::REJ_W'(crpc_pkg::REJECT_CAP - 1)))
            begin
                rej_next = rej_reg + 1'b1;
            end
            else
            begin
                rej_next       = '0;
                out_valid_next = 1'b1;
                out_char_next  = map_char;
                out_pos_next   = crpc_pkg::OUT_POS_W'(pos_reg);
                if (int'(pos_inc) < int'(length_reg))
                begin
                    pos_next         = pos_inc;
                    seen_next        = seen_upd;
                    out_verdict_next = crpc_pkg::VERDICT_MORE;
                end
                else if (!constrained || (seen_upd == class_mask_reg))
                begin
                    pos_next         = '0;
                    seen_next        = '0;
                    att_next         = '0;
                    out_verdict_next = crpc_pkg::VERDICT_ACCEPTED;
                end
                else if (att_reg >= crpc_pkg::ATT_W'(crpc_pkg::ATTEMPT_BUDGET - 1))
                begin
                    pos_next         = '0;
                    seen_next        = '0;
                    att_next         = '0;
                    out_verdict_next = crpc_pkg::VERDICT_EXHAUSTED;
                end
                else
                begin
                    pos_next         = '0;
                    seen_next        = '0;
                    att_next         = att_reg + 1'b1;
                    out_verdict_next = crpc_pkg::VERDICT_REJECTED;
                end
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                crpc_pkg::REG_CLASS_MASK:    class_mask_next = cfg_data[crpc_pkg::MASK_W-1:0];
                crpc_pkg::REG_EXCLUDE:       exclude_next    = cfg_data[0];
                crpc_pkg::REG_REQUIRE_EACH:  require_next    = cfg_data[0];
                crpc_pkg::REG_STRING_LENGTH: length_next     = cfg_data[crpc_pkg::LEN_W-1:0];
            endcase
            pos_next  = '0;
            seen_next = '0;
            rej_next  = '0;
            att_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            class_mask_reg <= 4'd15;
            exclude_reg    <= 1'b0;
            require_reg    <= 1'b0;
            length_reg     <= 8'd16;
            pos_reg        <= '0;
            seen_reg       <= '0;
            rej_reg        <= '0;
            att_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            class_mask_reg <= class_mask_next;
            exclude_reg    <= exclude_next;
            require_reg    <= require_next;
            length_reg     <= length_next;
            pos_reg        <= pos_next;
            seen_reg       <= seen_next;
            rej_reg        <= rej_next;
            att_reg        <= att_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg    <= out_char_next;
        out_pos_reg     <= out_pos_next;
        out_verdict_reg <= out_verdict_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_char_reg};
    assign m_tuser  = out_verdict_reg;

`include "constrained_random_password_chars_assert.svh"

    `CRPC_ASSERT_IMP(a_div_busy_in_div, clk, rst_n, state_reg == ST_DIV, div_res.busy)
    `CRPC_ASSERT_NEXT(a_done_to_fin, clk, rst_n, (state_reg == ST_DIV) && div_res.done, state_reg == ST_FIN)
    `CRPC_ASSERT_IMP(a_rej_bound, clk, rst_n, 1'b1, rej_reg < crpc_pkg::REJ_W'(crpc_pkg::REJECT_CAP))
    `CRPC_ASSERT_IMP(a_att_bound, clk, rst_n, 1'b1, att_reg < crpc_pkg::ATT_W'(crpc_pkg::ATTEMPT_BUDGET))

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import crpc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int ITEM_GOAL     = 1250;
    localparam int ALPHA_MAX     = 96;

    typedef struct packed {
        logic [CHAR_W-1:0]    code;
        logic [OUT_POS_W-1:0] position;
        logic [VERDICT_W-1:0] verdict;
    } char_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_WORD, ROW_CHECKED} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   idx;
        logic [7:0]   data;
        logic [31:0]  word;
        char_result_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // generator settings and string state as the block should hold them
    logic [MASK_W-1:0] cls_mask;
    logic              no_lookalike;
    logic              need_all;
    logic [LEN_W-1:0]  str_len;
    int unsigned       pos_cnt;
    logic [MASK_W-1:0] seen_mask;
    int unsigned       drop_run;
    int unsigned       failed_attempts;

    logic [CHAR_W-1:0]  alpha_chr [ALPHA_MAX];
    logic [CLASS_W-1:0] alpha_cls [ALPHA_MAX];
    int unsigned        alpha_len;

    char_result_t char_queue [$];
    plan_row_t    plan_rows [$];

    int  err_count = 0;
    int  cycle_cnt = 0;
    int  words_sent = 0;
    int  useful_words = 0;
    int  results_seen = 0;
    int  writes_done = 0;
    int  phase_cnt = 0;
    bit  steady_src = 1'b0;
    bit  steady_sink = 1'b0;

    constrained_random_password_chars u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
                 char_queue.size());
        $display("** constrained_random_password_chars: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        err_count++;
    endtask

    function automatic void clear_string_state();
        pos_cnt = 0;
        seen_mask = '0;
        drop_run = 0;
        failed_attempts = 0;
    endfunction

    function automatic void build_charset();
        string             txt;
        logic [7:0]        c;
        logic [CLASS_W-1:0] cls;
        alpha_len = 0;
        for (int k = 0; k < NUM_CLASS; k++)
        begin
            cls = k[CLASS_W-1:0];
            if (cls_mask[k])
            begin
                case (cls)
                    CLASS_LOWER:  txt = "abcdefghijklmnopqrstuvwxyz";
                    CLASS_UPPER:  txt = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
                    CLASS_DIGIT:  txt = "0123456789";
                    default:      txt = "!#$%&()*+,-./:;<=>?@[]^_{}~";
                endcase
                for (int i = 0; i < txt.len(); i++)
                begin
                    c = txt[i];
                    if (!(no_lookalike && (c == "0" || c == "O" || c == "1" ||
                                           c == "l" || c == "I")))
                    begin
                        alpha_chr[alpha_len] = c[CHAR_W-1:0];
                        alpha_cls[alpha_len] = cls;
                        alpha_len++;
                    end
                end
            end
        end
    endfunction

    function automatic void reset_generator();
        cls_mask = 4'd15;
        no_lookalike = 1'b0;
        need_all = 1'b0;
        str_len = 8'd16;
        clear_string_state();
        build_charset();
    endfunction

    // one random word through the generator; returns 1 when it yields a result
    function automatic bit draw_char(input logic [31:0] w, output char_result_t r);
        int unsigned     ncls;
        bit              strict;
        longint unsigned bound;
        int unsigned     idx;
        ncls = 0;
        for (int k = 0; k < NUM_CLASS; k++)
            ncls += cls_mask[k];
        strict = need_all && ncls > 1;
        r = '0;
        if (cls_mask == 0 || str_len == 0 || str_len > MAX_LENGTH ||
            (strict && str_len < ncls) || alpha_len == 0)
        begin
            clear_string_state();
            r.verdict = VERDICT_CFG_INVALID;
            return 1'b1;
        end
        bound = 64'h1_0000_0000 - (64'h1_0000_0000 % alpha_len);
        if (longint'(w) >= bound && drop_run + 1 < REJECT_CAP)
        begin
            drop_run++;
            return 1'b0;
        end
        drop_run = 0;
        idx = w % alpha_len;
        seen_mask[alpha_cls[idx]] = 1'b1;
        r.code = alpha_chr[idx];
        r.position = pos_cnt[OUT_POS_W-1:0];
        pos_cnt++;
        if (pos_cnt < str_len)
            r.verdict = VERDICT_MORE;
        else if (!strict || seen_mask == cls_mask)
        begin
            clear_string_state();
            r.verdict = VERDICT_ACCEPTED;
        end
        else
        begin
            failed_attempts++;
            if (failed_attempts >= ATTEMPT_BUDGET)
            begin
                clear_string_state();
                r.verdict = VERDICT_EXHAUSTED;
            end
            else
            begin
                pos_cnt = 0;
                seen_mask = '0;
                r.verdict = VERDICT_REJECTED;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap(input bit steady);
        int v;
        v = $urandom_range(0, 19);
        if (steady || v < 12)
            return 0;
        if (v < 19)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // words in the top zone are the ones the generator throws away
    function automatic logic [31:0] pick_word(input bit zone_only);
        longint unsigned zone;
        int              v;
        zone = 64'h1_0000_0000 % ((alpha_len == 0) ? 1 : alpha_len);
        v = $urandom_range(0, 31);
        if ((zone_only || v < 4) && zone != 0)
            return 32'hFFFF_FFFF - $urandom_range(0, int'(zone) - 1);
        if (v == 4)
            return 32'h0;
        if (v == 5)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [1:0] idx,
                                    input logic [7:0] data, input logic [31:0] word,
                                    input int code, input int pos,
                                    input logic [VERDICT_W-1:0] verdict);
        plan_row_t row;
        row.kind = kind;
        row.idx = idx;
        row.data = data;
        row.word = word;
        row.want.code = code[CHAR_W-1:0];
        row.want.position = pos[OUT_POS_W-1:0];
        row.want.verdict = verdict;
        plan_rows.push_back(row);
    endfunction

    // called at a falling edge; returns at a falling edge with the word taken
    task automatic push_word(input logic [31:0] w, input int gap, input bit typed_en,
                             input char_result_t typed);
        char_result_t r;
        bit           has_res;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has_res = draw_char(w, r);
        if (typed_en)
            char_queue.push_back(typed);
        else if (has_res)
            char_queue.push_back(r);
        if (has_res)
            useful_words++;
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_CLASS_MASK:    cls_mask = val[MASK_W-1:0];
            REG_EXCLUDE:       no_lookalike = val[0];
            REG_REQUIRE_EACH:  need_all = val[0];
            REG_STRING_LENGTH: str_len = val;
        endcase
        clear_string_state();
        build_charset();
        writes_done++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (char_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap(steady_sink);
                if (stall_left > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        char_result_t got;
        char_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.code = m_tdata[CHAR_W-1:0];
            got.position = m_tdata[CHAR_W +: OUT_POS_W];
            got.verdict = m_tuser;
            results_seen++;
            if (char_queue.size() == 0)
                report_mismatch("unexpected transaction, verdict", got.verdict, -1);
            else
            begin
                want = char_queue.pop_front();
                if (got.code !== want.code)
                    report_mismatch("char_code", got.code, want.code);
                if (got.position !== want.position)
                    report_mismatch("char_position", got.position, want.position);
                if (got.verdict !== want.verdict)
                    report_mismatch("verdict", got.verdict, want.verdict);
            end
        end
    end

    initial
    begin : stimulus
        bit          in_writes;
        int          n_items;
        int          start;
        int          v;
        logic [3:0]  m;
        logic        e;
        logic        q;
        logic [7:0]  len;
        logic [1:0]  ridx;
        logic [7:0]  rdata;

        reset_generator();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults after reset: all four classes, sixteen characters
        add_row(ROW_CHECKED, 0, 0, 32'd0,  "a", 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd88, "~", 1, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd26, "A", 2, VERDICT_MORE);
        add_row(ROW_WORD,    0, 0, 32'hFFFF_FFFF, 0, 0, VERDICT_MORE);
        add_row(ROW_WORD,    0, 0, 32'h8000_0001, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd1, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd0, "a", 0, VERDICT_ACCEPTED);
        // configurations the block must refuse
        add_row(ROW_WRITE, REG_CLASS_MASK, 8'd0, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'h1234_5678, 0, 0, VERDICT_CFG_INVALID);
        add_row(ROW_WRITE, REG_CLASS_MASK, 8'hFF, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd0, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd5, 0, 0, VERDICT_CFG_INVALID);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd129, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd5, 0, 0, VERDICT_CFG_INVALID);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd3, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_REQUIRE_EACH, 8'd1, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd7, 0, 0, VERDICT_CFG_INVALID);
        // coverage required, one character from each class
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd4, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd0,  "a", 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd26, "A", 1, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd52, "0", 2, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd62, "!", 3, VERDICT_ACCEPTED);
        // lower and upper only: a string missing upper is thrown away
        add_row(ROW_WRITE, REG_CLASS_MASK, 8'd3, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd2, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd0,  "a", 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd1,  "b", 1, VERDICT_REJECTED);
        add_row(ROW_CHECKED, 0, 0, 32'd0,  "a", 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd26, "A", 1, VERDICT_ACCEPTED);
        // lookalikes removed, longest string
        add_row(ROW_WRITE, REG_EXCLUDE, 8'd1, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_CLASS_MASK, 8'd2, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_REQUIRE_EACH, 8'd0, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_STRING_LENGTH, 8'd128, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd8, "J", 0, VERDICT_MORE);
        add_row(ROW_WORD,    0, 0, 32'd14, 0, 0, VERDICT_MORE);
        add_row(ROW_WORD,    0, 0, 32'hFFFF_FFFF, 0, 0, VERDICT_MORE);
        add_row(ROW_WRITE, REG_CLASS_MASK, 8'd4, 0, 0, 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'hFFFF_FFFF, "9", 0, VERDICT_MORE);
        add_row(ROW_CHECKED, 0, 0, 32'd0, "2", 1, VERDICT_MORE);

        in_writes = 1'b0;
        foreach (plan_rows[i])
        begin
            case (plan_rows[i].kind)
                ROW_WRITE:
                begin
                    if (!in_writes)
                        settle();
                    write_reg(plan_rows[i].idx, plan_rows[i].data);
                    in_writes = 1'b1;
                end
                ROW_WORD:
                begin
                    push_word(plan_rows[i].word, pick_gap(1'b0), 1'b0, '0);
                    in_writes = 1'b0;
                end
                default:
                begin
                    push_word(plan_rows[i].word, pick_gap(1'b0), 1'b1, plan_rows[i].want);
                    in_writes = 1'b0;
                end
            endcase
        end

        // long run of discarded words up to the point where one is used anyway
        settle();
        write_reg(REG_CLASS_MASK, 8'd15);
        write_reg(REG_EXCLUDE, 8'd0);
        write_reg(REG_REQUIRE_EACH, 8'd0);
        write_reg(REG_STRING_LENGTH, 8'd4);
        repeat (REJECT_CAP + 2)
            push_word(pick_word(1'b1), 0, 1'b0, '0);

        while (words_sent < ITEM_GOAL)
        begin
            settle();
            phase_cnt++;
            steady_src = ($urandom_range(0, 3) == 0);
            steady_sink = ($urandom_range(0, 3) == 0);
            m = ($urandom_range(0, 11) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            e = 1'($urandom_range(0, 1));
            q = 1'($urandom_range(0, 1));
            v = $urandom_range(0, 7);
            if (v < 3)
                len = 8'($urandom_range(1, 8));
            else if (v == 3)
                len = 8'(MAX_LENGTH);
            else if (v == 4)
                len = 8'd1;
            else if (v < 7)
                len = 8'($urandom_range(9, MAX_LENGTH - 1));
            else
                len = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(129, 255));
            start = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
            begin
                ridx = 2'(start + k);
                rdata = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'd0;
                case (ridx)
                    REG_CLASS_MASK:    rdata = {rdata[7:4], m};
                    REG_EXCLUDE:       rdata = {rdata[7:1], e};
                    REG_REQUIRE_EACH:  rdata = {rdata[7:1], q};
                    REG_STRING_LENGTH: rdata = len;
                endcase
                write_reg(ridx, rdata);
            end
            if (m == 0 || len == 0 || len > MAX_LENGTH)
                n_items = $urandom_range(2, 6);
            else if (len <= 8)
                n_items = $urandom_range(8, 40);
            else
                n_items = $urandom_range(len / 2, 2 * len + 10);
            for (int j = 0; j < n_items; j++)
                push_word(pick_word(1'b0), pick_gap(steady_src), 1'b0, '0);
        end

        settle();
        $display("run covered %0d words over %0d register phases and %0d writes,",
                 words_sent, phase_cnt, writes_done);
        $display("%0d words produced results, %0d result transactions compared",
                 useful_words, results_seen);
        if (err_count == 0)
            $display("** constrained_random_password_chars: PASSED **");
        else
            $display("** constrained_random_password_chars: FAILED **");
        $finish;
    end

endmodule

>>> constrained_random_password_chars.f
+incdir+src
src/crpc_pkg.sv
src/crpc_div.sv
src/crpc_map.sv
src/constrained_random_password_chars.sv
sim/tb_top.sv
